/* sv/agc_pkg.sv */
// Package for the anagram group classifier: sizes, beat structs and
// controller/datapath command and status types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package agc_pkg;
   localparam int MaxGroups    = 1024;
   localparam int AlphabetSize = 26;
   localparam int CountWidth   = 7;
   localparam int SigWidth     = AlphabetSize * CountWidth;
   localparam int GroupIdxW    = $clog2(MaxGroups);
   localparam int UsedW        = $clog2(MaxGroups + 1);
   localparam int SizeWidth    = 16;
   localparam int LetterWidth  = 5;
   localparam int OutIdxW      = 10;

   typedef struct packed {
      logic [LetterWidth-1:0] letter;
      logic                   letter_valid;
      logic                   word_end;
   } req_type;

   typedef struct packed {
      logic [OutIdxW-1:0]   group_index;
      logic                 is_new_group;
      logic [SizeWidth-1:0] group_size;
      logic                 table_full;
   } rsp_type;

   typedef struct packed {
      logic count;       // count letter of req beat
      logic clear;       // clear letter counters
      logic start_read;  // issue read of entry at scan pointer
      logic advance;     // advance scan pointer
      logic scan_reset;  // scan pointer to zero
      logic hit_update;  // write incremented size to matched entry
      logic store_new;   // store signature at groups_used
      logic load_rsp;    // capture response
   } cmd_type;

   typedef struct packed {
      logic scan_done;   // pointer reached groups_used
      logic match;       // registered read data equals counters
      logic full;        // groups_used at capacity
   } status_type;
endpackage
`default_nettype wire

/* sv/agc_datapath.sv */
// Datapath: letter counters, signature and size memories, scan pointer,
// response register. Uses agc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module agc_datapath (
   input  wire                   clock,
   input  wire                   reset,
   input  agc_pkg::req_type      req_data,
   input  agc_pkg::cmd_type      cmd,
   output agc_pkg::status_type   status,
   output agc_pkg::rsp_type      rsp_data
);
   import agc_pkg::*;

   logic [CountWidth-1:0] counts_ff [AlphabetSize];
   logic [CountWidth-1:0] counts_in [AlphabetSize];
   logic [SigWidth-1:0]   sig_mem [MaxGroups];
   logic [SizeWidth-1:0]  size_mem [MaxGroups];
   logic [SigWidth-1:0]   sig_rd_ff;
   logic [SizeWidth-1:0]  size_rd_ff;
   logic [UsedW-1:0]      ptr_ff, ptr_in;
   logic [UsedW-1:0]      used_ff, used_in;
   logic [GroupIdxW-1:0]  hit_idx_ff;
   rsp_type               rsp_ff, rsp_in;
   logic [SigWidth-1:0]   sig_flat;
   logic [SizeWidth-1:0]  size_inc;

   always_comb begin
      for (int i = 0; i < AlphabetSize; i++) begin
         sig_flat[i*CountWidth +: CountWidth] = counts_ff[i];
         counts_in[i] = counts_ff[i];
         if (cmd.clear) begin
            counts_in[i] = '0;
         end else if (cmd.count && req_data.letter_valid &&
                      ({1'b0, req_data.letter} == (LetterWidth+1)'(i)) &&
                      (counts_ff[i] != {CountWidth{1'b1}})) begin
            counts_in[i] = counts_ff[i] + 1'b1;
         end
      end
   end

   assign size_inc = (size_rd_ff == {SizeWidth{1'b1}}) ? size_rd_ff : size_rd_ff + 1'b1;

   always_comb begin
      ptr_in  = ptr_ff;
      used_in = used_ff;
      rsp_in  = rsp_ff;
      if (cmd.scan_reset) begin
         ptr_in = '0;
      end else if (cmd.advance) begin
         ptr_in = ptr_ff + 1'b1;
      end
      if (cmd.store_new) begin
         used_in = used_ff + 1'b1;
      end
      if (cmd.load_rsp) begin
         if (cmd.hit_update) begin
            rsp_in = '{group_index: OutIdxW'(hit_idx_ff), is_new_group: 1'b0,
                       group_size: size_inc, table_full: 1'b0};
         end else if (cmd.store_new) begin
            rsp_in = '{group_index: OutIdxW'(used_ff[GroupIdxW-1:0]),
                       is_new_group: 1'b1, group_size: SizeWidth'(1), table_full: 1'b0};
         end else begin
            rsp_in = '{group_index: '0, is_new_group: 1'b0,
                       group_size: '0, table_full: 1'b1};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AlphabetSize; i++) counts_ff[i] <= '0;
         ptr_ff  <= '0;
         used_ff <= '0;
      end else begin
         counts_ff <= counts_in;
         ptr_ff    <= ptr_in;
         used_ff   <= used_in;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.start_read) begin
         sig_rd_ff  <= sig_mem[ptr_ff[GroupIdxW-1:0]];
         size_rd_ff <= size_mem[ptr_ff[GroupIdxW-1:0]];
         hit_idx_ff <= ptr_ff[GroupIdxW-1:0];
      end
      if (cmd.store_new) begin
         sig_mem[used_ff[GroupIdxW-1:0]] <= sig_flat;
      end
      if (cmd.store_new) begin
         size_mem[used_ff[GroupIdxW-1:0]] <= SizeWidth'(1);
      end else if (cmd.hit_update) begin
         size_mem[hit_idx_ff] <= size_inc;
      end
   end

   assign status.scan_done = (ptr_ff == used_ff);
   assign status.match     = (sig_rd_ff == sig_flat);
   assign status.full      = (used_ff == UsedW'(MaxGroups));
   assign rsp_data         = rsp_ff;
endmodule
`default_nettype wire

/* sv/agc_controller.sv */
// Controller: sequences letter counting, table scan, store and response.
// Uses agc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module agc_controller (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  agc_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   input  agc_pkg::status_type   status,
   output agc_pkg::cmd_type      cmd
);
   import agc_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_ISSUE = 5'b00010,
      S_CHECK = 5'b00100,
      S_RESP = 5'b01000,
      S_HOLD = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      acc;
   logic      slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign acc       = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.scan_reset = 1'b1;
            if (acc) begin
               cmd.count = 1'b1;
               if (req_data.word_end) state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            if (status.scan_done) begin
               state_in = S_RESP;
            end else begin
               cmd.start_read = 1'b1;
               cmd.advance    = 1'b1;
               state_in       = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.match) begin
               if (slot_free) begin
                  cmd.hit_update = 1'b1;
                  cmd.load_rsp   = 1'b1;
                  state_in       = S_HOLD;
               end
            end else begin
               state_in = S_ISSUE;
            end
         end
         S_RESP: begin
            if (slot_free) begin
               cmd.load_rsp  = 1'b1;
               cmd.store_new = !status.full;
               state_in      = S_HOLD;
            end
         end
         S_HOLD: begin
            if (!rsp_valid_ff) begin
               cmd.clear    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

/* sv/anagram_group_classifier.sv */
// Anagram group classifier top level: controller plus datapath.
// Depends on agc_pkg, agc_controller, agc_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Letter beats are counted as they are taken. A word-end beat counts its
// letter, then scans the stored signatures in insertion order, one group
// at a time (registered read of the signature memory, then compare). Its
// response is loaded at the first match, else as a new group or table full,
// and the block is ready for the next beat when that response is valid.
// The response sits in an output register, so the next word's letters
// are taken while it waits; a word end that finishes its scan first holds
// until that response is taken. No clearing pass: the table uses a fill count.
module anagram_group_classifier (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  agc_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output agc_pkg::rsp_type   rsp_data
);
   import agc_pkg::*;

   cmd_type    cmd;
   status_type status;

   agc_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .status(status), .cmd(cmd)
   );

   agc_datapath u_dp (
      .clock(clock), .reset(reset), .req_data(req_data), .cmd(cmd),
      .status(status), .rsp_data(rsp_data)
   );

   a_store_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.store_new |-> !status.full) else $error("store into full table");
   a_hit_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.hit_update && cmd.store_new)) else $error("hit and store together");
   a_full_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.table_full |-> rsp_data.group_size == '0 &&
      !rsp_data.is_new_group) else $error("full response fields");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");
endmodule
`default_nettype wire
